### rtl/core/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants for the sweep point frequency block
// Register indexes, field widths and the fixed bandwidth table.
// ----------------------------------------------------------------------------
package spf_pkg;

  localparam int FREQ_W = 48;
  localparam int RF_W   = 49;
  localparam int STEP_W = 31;
  localparam int RBW_W  = 32;
  localparam int SEL_W  = 3;
  localparam int IDX_W  = 16;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 48;

  localparam logic [CIDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_STOP   = 3'd1;
  localparam logic [CIDX_W-1:0] REG_RBWSEL = 3'd2;
  localparam logic [CIDX_W-1:0] REG_CUSTOM = 3'd3;

  localparam logic [SEL_W-1:0] SEL_10K    = 3'd0;
  localparam logic [SEL_W-1:0] SEL_30K    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_100K   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_300K   = 3'd3;
  localparam logic [SEL_W-1:0] SEL_1M     = 3'd4;

  localparam logic [RBW_W-1:0] RBW_DEFAULT = 32'd100000;

  // plan handed from the planner to the point pipeline
  typedef struct packed {
    logic [FREQ_W-1:0] start;
    logic [STEP_W-1:0] step;
    logic              error;
  } plan_t;

  // bandwidth in Hz for a selector; codes above 1M mean custom (100 kHz if 0)
  function automatic logic [RBW_W-1:0] pick_rbw(input logic [SEL_W-1:0] sel,
                                                input logic [RBW_W-1:0] custom);
    logic [RBW_W-1:0] bw;
    unique case (sel)
      SEL_10K:  bw = 32'd10000;
      SEL_30K:  bw = 32'd30000;
      SEL_100K: bw = 32'd100000;
      SEL_300K: bw = 32'd300000;
      SEL_1M:   bw = 32'd1000000;
      default:  bw = (custom != '0) ? custom : RBW_DEFAULT;
    endcase
    return bw;
  endfunction

endpackage

### rtl/core/spf_planner.sv
// ----------------------------------------------------------------------------
// spf_planner: configuration registers and sweep plan
// Holds the registers, derives the step and works out the point count with a
// bit-serial divider after reset and after every write.
// ----------------------------------------------------------------------------
module spf_planner #(
  parameter int MAX_POINTS = 4096,
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [spf_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [spf_pkg::CDAT_W-1:0]   cfg_data,
  output spf_pkg::plan_t               plan,
  output logic [CW-1:0]                count,
  output logic                         busy
);

  localparam int FW = spf_pkg::FREQ_W;
  localparam int SW = spf_pkg::STEP_W;
  localparam logic [5:0] LAST_ITER = 6'(FW - 1);

  logic [FW-1:0]                start_freq;
  logic [FW-1:0]                stop_freq;
  logic [spf_pkg::SEL_W-1:0]    rbw_select;
  logic [spf_pkg::RBW_W-1:0]    custom_rbw;

  logic              load;
  logic [5:0]        iter;
  logic [FW-1:0]     dvd;     // dividend shifting out, quotient shifting in
  logic [SW-1:0]     rem;
  logic [SW-1:0]     step;
  logic              error;

  logic [spf_pkg::RBW_W-1:0] bw;
  logic [SW-1:0]     step_next;
  logic [SW:0]       trial;
  logic [SW:0]       diff;
  logic              qbit;
  logic [FW-1:0]     dvd_next;
  logic [SW-1:0]     rem_next;
  logic [CW-1:0]     count_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    bw        = spf_pkg::pick_rbw(rbw_select, custom_rbw);
    step_next = bw[spf_pkg::RBW_W-1:1];
    if (step_next == '0) begin
      step_next = SW'(1);
    end
    trial    = {rem, dvd[FW-1]};
    diff     = trial - {1'b0, step};
    qbit     = (trial >= {1'b0, step});
    rem_next = qbit ? diff[SW-1:0] : trial[SW-1:0];
    dvd_next = {dvd[FW-2:0], qbit};
    // count = quotient + 1, kept within 2..MAX_POINTS
    if (dvd_next >= FW'(MAX_POINTS - 1)) begin
      count_next = CW'(MAX_POINTS);
    end else if (dvd_next == '0) begin
      count_next = CW'(2);
    end else begin
      count_next = CW'(dvd_next + FW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_freq <= '0;
      stop_freq  <= '0;
      rbw_select <= spf_pkg::SEL_100K;
      custom_rbw <= '0;
      load       <= 1'b1;
      busy       <= 1'b1;
      iter       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spf_pkg::REG_START:  start_freq <= cfg_data[FW-1:0];
        spf_pkg::REG_STOP:   stop_freq  <= cfg_data[FW-1:0];
        spf_pkg::REG_RBWSEL: rbw_select <= cfg_data[spf_pkg::SEL_W-1:0];
        spf_pkg::REG_CUSTOM: custom_rbw <= cfg_data[spf_pkg::RBW_W-1:0];
        default: ;
      endcase
      load <= 1'b1;
      busy <= 1'b1;
    end else if (load) begin
      load <= 1'b0;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 6'd1;
      if (iter == LAST_ITER) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst && !(cfg_valid && cfg_ready)) begin
      if (load) begin
        step  <= step_next;
        error <= (stop_freq <= start_freq);
        dvd   <= stop_freq - start_freq;
        rem   <= '0;
      end else if (busy) begin
        dvd <= dvd_next;
        rem <= rem_next;
        if (iter == LAST_ITER) begin
          count <= count_next;
        end
      end
    end
  end

  assign plan.start = start_freq;
  assign plan.step  = step;
  assign plan.error = error;

endmodule

### rtl/core/spf_pipe.sv
// ----------------------------------------------------------------------------
// spf_pipe: three-stage point pipeline
// Clamp the index, multiply by the step, add the start frequency.
// ----------------------------------------------------------------------------
module spf_pipe #(
  parameter int MAX_POINTS = 4096,
  parameter int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spf_pkg::plan_t                plan,
  input  logic [CW-1:0]                 count,
  input  logic                          hold,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [spf_pkg::IDX_W-1:0]     sweep_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [spf_pkg::RF_W-1:0]      rf_freq,
  output logic [spf_pkg::STEP_W-1:0]    step_freq,
  output logic [CW-1:0]                 sweep_count,
  output logic                          plan_error
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int XW = (CW > spf_pkg::IDX_W) ? CW : spf_pkg::IDX_W + 1;
  localparam int PW = IW + spf_pkg::STEP_W;

  logic           v1, v2;
  logic           r1, r2, r3;
  logic [IW-1:0]  idx1;
  logic [PW-1:0]  prod2;
  logic [XW-1:0]  idx_x, cnt_x, last_x;

  assign r3 = !out_valid || !out_stall;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_stall = hold || !r1;

  always_comb begin
    idx_x  = XW'(sweep_index);
    cnt_x  = XW'(count);
    last_x = cnt_x - XW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= in_valid && !in_stall;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        out_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid && !in_stall) begin
      idx1 <= (idx_x >= cnt_x) ? last_x[IW-1:0] : idx_x[IW-1:0];
    end
    if (r2 && v1) begin
      prod2 <= PW'(idx1) * PW'(plan.step);
    end
    if (r3 && v2) begin
      if (plan.error) begin
        rf_freq     <= '0;
        step_freq   <= '0;
        sweep_count <= '0;
        plan_error  <= 1'b1;
      end else begin
        rf_freq     <= spf_pkg::RF_W'(plan.start) + spf_pkg::RF_W'(prod2);
        step_freq   <= plan.step;
        sweep_count <= count;
        plan_error  <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/sweep_point_frequency.sv
// ----------------------------------------------------------------------------
// sweep_point_frequency: spectrum sweep point planner
// Returns start + index*step for each point index, with step and count.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  cfg       cfg_valid/cfg_ready  cfg_index, cfg_data
//  in        in_valid/in_stall    sweep_index
//  out       out_valid/out_stall  rf_freq, step_freq, sweep_count, plan_error
//
//  One word per cycle in steady state, while out_stall is low and the
//  planner is idle. Three register stages (clamp, multiply, add) lie
//  between the accepted index and its outgoing word. After reset and
//  after every configuration write the planner runs a bit-serial
//  divider for the point count, during which in_stall is held high.
//  Reset (rst, synchronous) loads the register defaults and starts the plan.
//  Each stage advances independently, so bubbles close up under out_stall.
// ----------------------------------------------------------------------------
module sweep_point_frequency #(
  parameter int MAX_POINTS = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spf_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [spf_pkg::CDAT_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spf_pkg::IDX_W-1:0]         sweep_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spf_pkg::RF_W-1:0]          rf_freq,
  output logic [spf_pkg::STEP_W-1:0]        step_freq,
  output logic [$clog2(MAX_POINTS + 1)-1:0] sweep_count,
  output logic                              plan_error
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  spf_pkg::plan_t plan;
  logic [CW-1:0]  count;
  logic           busy;

  // registers, step and divider for the point count
  spf_planner #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_planner (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plan      (plan),
    .count     (count),
    .busy      (busy)
  );

  // per-point pipeline
  spf_pipe #(.MAX_POINTS(MAX_POINTS), .CW(CW)) u_pipe (
    .clk         (clk),
    .rst         (rst),
    .plan        (plan),
    .count       (count),
    .hold        (busy),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sweep_index (sweep_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rf_freq     (rf_freq),
    .step_freq   (step_freq),
    .sweep_count (sweep_count),
    .plan_error  (plan_error)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sweep_point_frequency
// Each accepted point index is turned into a predicted sweep point and
// checked, field by field and in order, against the words leaving the block.
// Phases of random configuration, directed corners and random indexes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAXP = 4096;
  localparam int CNT_W = 13;
  localparam int WDOG_LIMIT = 20000;

  localparam int FREQ_W = spf_pkg::FREQ_W;
  localparam int RF_W   = spf_pkg::RF_W;
  localparam int STEP_W = spf_pkg::STEP_W;
  localparam int RBW_W  = spf_pkg::RBW_W;
  localparam int SEL_W  = spf_pkg::SEL_W;
  localparam int IDX_W  = spf_pkg::IDX_W;
  localparam int CIDX_W = spf_pkg::CIDX_W;
  localparam int CDAT_W = spf_pkg::CDAT_W;

  typedef struct packed {
    logic [RF_W-1:0]   rf;
    logic [STEP_W-1:0] step;
    logic [CNT_W-1:0]  cnt;
    logic              err;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CDAT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] sweep_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [RF_W-1:0] rf_freq;
  logic [STEP_W-1:0] step_freq;
  logic [CNT_W-1:0] sweep_count;
  logic plan_error;

  // shadow of the block's registers
  logic [FREQ_W-1:0] sh_start, sh_stop;
  logic [SEL_W-1:0]  sh_sel;
  logic [RBW_W-1:0]  sh_custom;

  logic [IDX_W-1:0] index_queue[$];
  point_t           point_queue[$];
  int  fails = 0;
  int  idle_cycles = 0;
  logic hold_go = 1'b0;   // asks for the long receiver hold-off
  logic hold_done = 1'b0;
  int  hold_off = 0;
  int  in_gap = 0, out_gap = 0;

  sweep_point_frequency #(.MAX_POINTS(MAXP)) dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic point_t plan_point(logic [IDX_W-1:0] idx);
    point_t p;
    logic [63:0] bw, step, span, cnt, k;
    p = '0;
    if (sh_stop <= sh_start) begin
      p.err = 1'b1;
      return p;
    end
    case (sh_sel)
      spf_pkg::SEL_10K:  bw = 64'd10000;
      spf_pkg::SEL_30K:  bw = 64'd30000;
      spf_pkg::SEL_100K: bw = 64'd100000;
      spf_pkg::SEL_300K: bw = 64'd300000;
      spf_pkg::SEL_1M:   bw = 64'd1000000;
      default:  bw = (sh_custom != 0) ? 64'(sh_custom) : 64'd100000;
    endcase
    step = bw >> 1;
    if (step == 0) step = 1;
    span = 64'(sh_stop) - 64'(sh_start);
    cnt = span / step + 1;
    if (cnt > MAXP) cnt = MAXP;
    if (cnt < 2) cnt = 2;
    k = 64'(idx);
    if (k >= cnt) k = cnt - 1;
    p.rf = RF_W'(64'(sh_start) + k * step);
    p.step = STEP_W'(step);
    p.cnt = CNT_W'(cnt);
    return p;
  endfunction

  // driver: one word per queued index, random gap before each
  always @(posedge clk) begin
    if (rst) begin
      in_gap <= 0;
    end else if (in_valid && !in_stall) begin
      point_queue.push_back(plan_point(sweep_index));
      void'(index_queue.pop_front());
      in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    end else if (!in_valid && in_gap > 0) begin
      in_gap <= in_gap - 1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (index_queue.size() > 0 && in_gap == 0) begin
      in_valid <= 1'b1;
      sweep_index <= index_queue[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // monitor: compare each word leaving the block with the oldest prediction
  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (point_queue.size() == 0) begin
          $display("%0t: unexpected word rf=%0d", $time, rf_freq);
          fails <= fails + 1;
        end else begin
          e = point_queue.pop_front();
          if (rf_freq !== e.rf || step_freq !== e.step ||
              sweep_count !== e.cnt || plan_error !== e.err) begin
            $display("%0t: expected rf=%0d step=%0d cnt=%0d err=%0b", $time,
                     e.rf, e.step, e.cnt, e.err);
            $display("%0t: actual   rf=%0d step=%0d cnt=%0d err=%0b", $time,
                     rf_freq, step_freq, sweep_count, plan_error);
            fails <= fails + 1;
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("sweep_point_frequency: mismatch");
        $finish;
      end
    end
  end

  // long hold-off, counted here once the stimulus asks for it
  always @(negedge clk) begin
    if (rst) begin
      hold_off <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_off <= 300;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // receiver: random stall per word, plus the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid)
        out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      spf_pkg::REG_START:  sh_start = val[FREQ_W-1:0];
      spf_pkg::REG_STOP:   sh_stop = val[FREQ_W-1:0];
      spf_pkg::REG_RBWSEL: sh_sel = val[SEL_W-1:0];
      spf_pkg::REG_CUSTOM: sh_custom = val[RBW_W-1:0];
      default: ;
    endcase
  endtask

  // wait until the pipeline has drained before touching registers
  task automatic drain();
    while (index_queue.size() > 0 || point_queue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_plan(logic [47:0] st, logic [47:0] sp, logic [2:0] sel,
                          logic [31:0] cu);
    drain();
    write_reg(spf_pkg::REG_START, st);
    write_reg(spf_pkg::REG_STOP, sp);
    write_reg(spf_pkg::REG_RBWSEL, 48'(sel));
    write_reg(spf_pkg::REG_CUSTOM, 48'(cu));
  endtask

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(0, 4))
      0: return IDX_W'($urandom);
      1: return IDX_W'($urandom_range(0, 3));
      2: return IDX_W'($urandom_range(4090, 4100));
      default: return IDX_W'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    logic [47:0] st, sp;
    logic [31:0] cu;
    sh_start = '0;
    sh_stop = '0;
    sh_sel = spf_pkg::SEL_100K;
    sh_custom = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: stop == start, so every point is a plan error
    index_queue.push_back(16'd0);
    index_queue.push_back(16'hFFFF);

    // directed corners
    set_plan(48'd1000000, 48'd2000000, spf_pkg::SEL_10K, 32'd0);
    index_queue.push_back(16'd0);
    index_queue.push_back(16'd200);
    index_queue.push_back(16'd201);
    index_queue.push_back(16'hFFFF);
    set_plan(48'd0, 48'hFFFF_FFFF_FFFF, spf_pkg::SEL_1M, 32'hFFFF_FFFF);
    index_queue.push_back(16'd4095);
    index_queue.push_back(16'hFFFF);
    // codes above 1M: zero custom value, then nonzero custom values
    set_plan(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF, 3'd5, 32'd0);
    index_queue.push_back(16'd1);
    index_queue.push_back(16'hFFFF);
    set_plan(48'd0, 48'hFFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    index_queue.push_back(16'd4095);
    index_queue.push_back(16'hAAAA);
    set_plan(48'd5, 48'd5000, 3'd6, 32'd1);
    index_queue.push_back(16'd4095);
    index_queue.push_back(16'd4994);
    set_plan(48'd100, 48'd130000, spf_pkg::SEL_30K, 32'd0);
    index_queue.push_back(16'd9);
    set_plan(48'd100, 48'd400100, spf_pkg::SEL_300K, 32'd0);
    index_queue.push_back(16'd3);
    set_plan(48'd500, 48'd400, spf_pkg::SEL_100K, 32'd0);
    index_queue.push_back(16'd7);

    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      st = 48'({$urandom, $urandom});
      if ($urandom_range(0, 1)) st = st >> $urandom_range(0, 47);
      case ($urandom_range(0, 3))
        0: sp = st + 48'($urandom_range(0, 3000000));
        1: sp = st - 48'($urandom_range(0, 10));
        default: sp = 48'({$urandom, $urandom});
      endcase
      cu = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5);
      set_plan(st, sp, 3'($urandom_range(0, 7)), cu);
      if (ph == 3) begin
        // long hold-off so the block fills and stalls its input
        hold_go = 1'b1;
        for (int i = 0; i < 40; i++) index_queue.push_back(rand_index());
      end
      for (int i = 0; i < 50; i++) index_queue.push_back(rand_index());
    end

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0 && point_queue.size() == 0)
      $display("sweep_point_frequency: match");
    else
      $display("sweep_point_frequency: mismatch");
    $finish;
  end
endmodule
